[rtl/command_packet_deframer_defines.svh]
`ifndef COMMAND_PACKET_DEFRAMER_DEFINES_SVH
`define COMMAND_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cpd_pkg.sv]
package cpd_pkg;

  localparam int MAX_FRAME_SAMPLES = 256;

  localparam logic [31:0] MAGIC_WORD    = 32'h4843_5542;
  localparam logic [7:0]  PROTO_VERSION = 8'h01;
  localparam logic [7:0]  CMD_PING      = 8'h01;
  localparam logic [7:0]  CMD_START     = 8'h03;
  localparam logic [7:0]  CMD_STOP      = 8'h05;

  localparam int WINDOW_BYTES = 12;
  localparam int FILL_W       = 4;
  localparam int LEN_W        = 7;
  localparam int SEQ_W        = 32;
  localparam int CNT_W        = 32;
  localparam int SAMPLE_W     = 9;
  localparam int PBYTES_W     = 10;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 7'd64;

  // Stream packing
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 144;
  localparam int OUT_SEQ_LSB     = 0;
  localparam int OUT_ERR_LSB     = 32;
  localparam int OUT_UPTIME_LSB  = 35;
  localparam int OUT_FRAMES_LSB  = 67;
  localparam int OUT_SAMPLES_LSB = 99;
  localparam int OUT_BYTES_LSB   = 131;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_AUDIO = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  typedef enum logic [0:0] {
    CFG_MIC_READY       = 1'b0,
    CFG_MAX_PAYLOAD_LEN = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    RK_PONG      = 3'd0,
    RK_START_ACK = 3'd1,
    RK_STOP_ACK  = 3'd2,
    RK_ERROR     = 3'd3,
    RK_AUDIO     = 3'd4
  } reply_kind_t;

  typedef enum logic [2:0] {
    ERR_MIC_NOT_READY     = 3'd0,
    ERR_ALREADY_STREAMING = 3'd1,
    ERR_START_PAYLOAD     = 3'd2,
    ERR_STOP_PAYLOAD      = 3'd3,
    ERR_UNSUPPORTED       = 3'd4,
    ERR_TOO_LARGE         = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    EV_COMMAND   = 2'd0,
    EV_TOO_LARGE = 2'd1,
    EV_AUDIO     = 2'd2,
    EV_TICK      = 2'd3
  } event_kind_t;

  typedef struct packed {
    event_kind_t         kind;
    logic [7:0]          cmd_type;
    logic                has_payload;
    logic [SEQ_W-1:0]    seq_num;
    logic [SAMPLE_W-1:0] samples;
    logic                link_ok;
  } event_t;

  typedef struct packed {
    reply_kind_t         kind;
    logic [SEQ_W-1:0]    seq_num;
    err_code_t           err;
    logic [CNT_W-1:0]    uptime;
    logic [CNT_W-1:0]    frames;
    logic [CNT_W-1:0]    samples;
    logic [PBYTES_W-1:0] payload_bytes;
  } result_t;

endpackage

[rtl/cpd_front.sv]
module cpd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [1:0]                    action,
  input  logic [7:0]                    rx_byte,
  input  logic [cpd_pkg::SAMPLE_W-1:0]  sample_count,
  input  logic                          link_ok,
  input  logic [cpd_pkg::LEN_W-1:0]     max_payload_len,
  output logic                          ev_push,
  output cpd_pkg::event_t               ev
);

  // Bytes 0..10 of the window; byte 11 is always the incoming one.
  logic [7:0]                  window [cpd_pkg::WINDOW_BYTES-1];
  logic [cpd_pkg::FILL_W-1:0]  fill, fill_next;
  logic                        skipping, skipping_next;
  logic [cpd_pkg::LEN_W-1:0]   payload_left, payload_left_next;
  logic [7:0]                  held_type, held_type_next;
  logic [cpd_pkg::SEQ_W-1:0]   held_seq, held_seq_next;

  logic                        win_full, header_ok, too_large;
  logic                        win_write, win_shift;
  logic [31:0]                 magic;
  logic [15:0]                 length;
  logic [cpd_pkg::SEQ_W-1:0]   seq_in;

  assign win_full  = (fill == cpd_pkg::FILL_W'(cpd_pkg::WINDOW_BYTES - 1));
  assign magic     = {window[3], window[2], window[1], window[0]};
  assign length    = {window[7], window[6]};
  assign seq_in    = {rx_byte, window[10], window[9], window[8]};
  assign header_ok = (magic == cpd_pkg::MAGIC_WORD) && (window[4] == cpd_pkg::PROTO_VERSION);
  assign too_large = length > {9'd0, max_payload_len};

  always_comb begin
    fill_next         = fill;
    skipping_next     = skipping;
    payload_left_next = payload_left;
    held_type_next    = held_type;
    held_seq_next     = held_seq;
    win_write         = 1'b0;
    win_shift         = 1'b0;
    ev_push           = 1'b0;
    ev                = '0;
    if (in_fire) begin
      unique case (action)
        cpd_pkg::ACT_BYTE: begin
          if (skipping) begin
            payload_left_next = payload_left - 1'b1;
            if (payload_left == cpd_pkg::LEN_W'(1)) begin
              skipping_next  = 1'b0;
              ev_push        = 1'b1;
              ev.kind        = cpd_pkg::EV_COMMAND;
              ev.cmd_type    = held_type;
              ev.has_payload = 1'b1;
              ev.seq_num     = held_seq;
            end
          end else if (!win_full) begin
            win_write = 1'b1;
            fill_next = fill + 1'b1;
          end else if (!header_ok) begin
            win_shift = 1'b1;
          end else if (too_large) begin
            win_shift  = 1'b1;
            ev_push    = 1'b1;
            ev.kind    = cpd_pkg::EV_TOO_LARGE;
            ev.seq_num = seq_in;
          end else begin
            held_type_next = window[5];
            held_seq_next  = seq_in;
            fill_next      = '0;
            if (length[cpd_pkg::LEN_W-1:0] == '0) begin
              ev_push        = 1'b1;
              ev.kind        = cpd_pkg::EV_COMMAND;
              ev.cmd_type    = window[5];
              ev.has_payload = 1'b0;
              ev.seq_num     = seq_in;
            end else begin
              skipping_next     = 1'b1;
              payload_left_next = length[cpd_pkg::LEN_W-1:0];
            end
          end
        end
        cpd_pkg::ACT_AUDIO: begin
          // Empty frames are dropped here; oversized ones are clamped.
          if (sample_count != '0) begin
            ev_push    = 1'b1;
            ev.kind    = cpd_pkg::EV_AUDIO;
            ev.link_ok = link_ok;
            if (32'(sample_count) > cpd_pkg::MAX_FRAME_SAMPLES) begin
              ev.samples = cpd_pkg::SAMPLE_W'(cpd_pkg::MAX_FRAME_SAMPLES);
            end else begin
              ev.samples = sample_count;
            end
          end
        end
        cpd_pkg::ACT_TICK: begin
          ev_push = 1'b1;
          ev.kind = cpd_pkg::EV_TICK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      skipping     <= 1'b0;
      payload_left <= '0;
      held_type    <= '0;
      held_seq     <= '0;
    end else begin
      fill         <= fill_next;
      skipping     <= skipping_next;
      payload_left <= payload_left_next;
      held_type    <= held_type_next;
      held_seq     <= held_seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (win_shift) begin
      for (int i = 0; i < cpd_pkg::WINDOW_BYTES - 2; i++) begin
        window[i] <= window[i+1];
      end
      window[cpd_pkg::WINDOW_BYTES-2] <= rx_byte;
    end else if (win_write) begin
      window[fill] <= rx_byte;
    end
  end

endmodule

[rtl/cpd_queue.sv]
module cpd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cpd_pkg::event_t push_ev,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output cpd_pkg::event_t head_ev
);

  cpd_pkg::event_t                 slots [cpd_pkg::QUEUE_DEPTH];
  logic [cpd_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cpd_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = (count == cpd_pkg::QUEUE_CNT_W'(cpd_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_ev   = slots[rd_ptr];

  function automatic logic [cpd_pkg::QUEUE_PTR_W-1:0] ptr_inc(
    input logic [cpd_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == cpd_pkg::QUEUE_PTR_W'(cpd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

endmodule

[rtl/cpd_back.sv]
module cpd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             ev_valid,
  input  cpd_pkg::event_t  ev,
  output logic             pop,
  input  logic             mic_ready,
  output logic             res_valid,
  input  logic             res_ready,
  output cpd_pkg::result_t res
);

  logic                      streaming, streaming_next;
  logic [cpd_pkg::CNT_W-1:0] audio_seq, audio_seq_next;
  logic [cpd_pkg::CNT_W-1:0] frames, frames_next;
  logic [cpd_pkg::CNT_W-1:0] samples, samples_next;
  logic [cpd_pkg::CNT_W-1:0] ticks, ticks_next;
  logic                      emit;
  cpd_pkg::result_t          res_next;

  assign pop = ev_valid && (!res_valid || res_ready);

  always_comb begin
    streaming_next = streaming;
    audio_seq_next = audio_seq;
    frames_next    = frames;
    samples_next   = samples;
    ticks_next     = ticks;
    emit           = 1'b0;
    res_next       = '0;
    res_next.seq_num = ev.seq_num;
    unique case (ev.kind)
      cpd_pkg::EV_COMMAND: begin
        emit = 1'b1;
        unique case (ev.cmd_type)
          cpd_pkg::CMD_PING: begin
            res_next.kind   = cpd_pkg::RK_PONG;
            res_next.uptime = ticks;
          end
          cpd_pkg::CMD_START: begin
            res_next.kind = cpd_pkg::RK_ERROR;
            if (ev.has_payload) begin
              res_next.err = cpd_pkg::ERR_START_PAYLOAD;
            end else if (!mic_ready) begin
              res_next.err = cpd_pkg::ERR_MIC_NOT_READY;
            end else if (streaming) begin
              res_next.err = cpd_pkg::ERR_ALREADY_STREAMING;
            end else begin
              res_next.kind  = cpd_pkg::RK_START_ACK;
              streaming_next = 1'b1;
              audio_seq_next = '0;
              frames_next    = '0;
              samples_next   = '0;
            end
          end
          cpd_pkg::CMD_STOP: begin
            if (ev.has_payload) begin
              res_next.kind = cpd_pkg::RK_ERROR;
              res_next.err  = cpd_pkg::ERR_STOP_PAYLOAD;
            end else begin
              res_next.kind    = cpd_pkg::RK_STOP_ACK;
              res_next.frames  = frames;
              res_next.samples = samples;
              streaming_next   = 1'b0;
            end
          end
          default: begin
            res_next.kind = cpd_pkg::RK_ERROR;
            res_next.err  = cpd_pkg::ERR_UNSUPPORTED;
          end
        endcase
      end
      cpd_pkg::EV_TOO_LARGE: begin
        emit          = 1'b1;
        res_next.kind = cpd_pkg::RK_ERROR;
        res_next.err  = cpd_pkg::ERR_TOO_LARGE;
      end
      cpd_pkg::EV_AUDIO: begin
        if (streaming) begin
          if (!ev.link_ok) begin
            streaming_next = 1'b0;
          end else begin
            emit                   = 1'b1;
            res_next.kind          = cpd_pkg::RK_AUDIO;
            res_next.seq_num       = audio_seq;
            res_next.payload_bytes = {ev.samples, 1'b0};
            audio_seq_next         = audio_seq + 1'b1;
            frames_next            = frames + 1'b1;
            samples_next           = samples + cpd_pkg::CNT_W'(ev.samples);
          end
        end
      end
      cpd_pkg::EV_TICK: begin
        ticks_next = ticks + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streaming <= 1'b0;
      audio_seq <= '0;
      frames    <= '0;
      samples   <= '0;
      ticks     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        streaming <= streaming_next;
        audio_seq <= audio_seq_next;
        frames    <= frames_next;
        samples   <= samples_next;
        ticks     <= ticks_next;
      end
      if (pop && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

endmodule

[rtl/command_packet_deframer.sv]
// Channel   Direction  Transaction carries
// s_*       in         one event: received byte, captured audio frame or millisecond tick
// m_*       out        one reply: pong, start or stop acknowledge, error or audio header
// cfg_*     in         one register write: mic_ready or max_payload_len
//
// An input transaction can be taken in every cycle. The front end classifies it in
// the cycle it arrives and queues an event; the back end executes one event per cycle
// while m_* is not stalled; a reply passes the event queue and then the output register.
// The four-entry event queue drops s_tready only when it fills behind a stalled m_*.
// Reset is synchronous and clears fill level, flags, counters and the queue; the
// header bytes themselves are not cleared.
module command_packet_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: rx_byte [7:0], frame_sample_count [16:8], link_ok [17], zero fill
  input  logic [cpd_pkg::IN_TDATA_W-1:0]    s_tdata,
  // s_tuser: action [1:0]
  input  logic [1:0]                        s_tuser,
  // Reply stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: reply_sequence [31:0], error_code [34:32], uptime [66:35],
  // frames_total [98:67], samples_total [130:99], audio_payload_bytes [140:131],
  // zero fill
  output logic [cpd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // m_tuser: reply_kind [2:0]
  output logic [2:0]                        m_tuser,
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [cpd_pkg::LEN_W-1:0]         cfg_data
);

  // Configuration registers. Writes are to be made only while the block is idle
  // (not enforced by the block); writes are always accepted and take effect at once.
  logic                        mic_ready;
  logic [cpd_pkg::LEN_W-1:0]   max_payload_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mic_ready       <= 1'b0;
      max_payload_len <= cpd_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cpd_pkg::CFG_MIC_READY:       mic_ready       <= cfg_data[0];
        cpd_pkg::CFG_MAX_PAYLOAD_LEN: max_payload_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end takes a transaction whenever the event queue has room, even
  // if the transaction ends up producing no event.
  logic             q_full, q_not_empty, q_pop, ev_push, in_fire;
  cpd_pkg::event_t  ev_in, ev_head;
  cpd_pkg::result_t res;

  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;

  cpd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_fire         (in_fire),
    .action          (s_tuser),
    .rx_byte         (s_tdata[7:0]),
    .sample_count    (s_tdata[16:8]),
    .link_ok         (s_tdata[17]),
    .max_payload_len (max_payload_len),
    .ev_push         (ev_push),
    .ev              (ev_in)
  );

  cpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_push),
    .push_ev   (ev_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_ev   (ev_head)
  );

  // The back end holds the stream state and counters and owns the output
  // register; it pulls the next event whenever that register is free or
  // being emptied in the same cycle.
  cpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (q_not_empty),
    .ev        (ev_head),
    .pop       (q_pop),
    .mic_ready (mic_ready),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {
    3'd0,
    res.payload_bytes,
    res.samples,
    res.frames,
    res.uptime,
    res.err,
    res.seq_num
  };

endmodule

[rtl/cpd_checker.sv]
`include "command_packet_deframer_defines.svh"

module cpd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cpd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser
);

  `CPD_ASSERT_NEXT(a_reply_held, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled reply changed")

  `CPD_ASSERT_NEXT(a_reset_empties, clk, 1'b0, rst, !m_tvalid, "reply offered straight after reset")

  `CPD_ASSERT_IMPL(a_audio_fields, clk, rst, m_tvalid && (m_tuser == cpd_pkg::RK_AUDIO), (m_tdata[cpd_pkg::OUT_ERR_LSB +: 3] == 3'd0) && (m_tdata[cpd_pkg::OUT_BYTES_LSB +: cpd_pkg::PBYTES_W] != '0) && (m_tdata[cpd_pkg::OUT_BYTES_LSB] == 1'b0), "audio header with bad fields")

  `CPD_ASSERT_IMPL(a_error_fields, clk, rst, m_tvalid && (m_tuser == cpd_pkg::RK_ERROR), (m_tdata[cpd_pkg::OUT_UPTIME_LSB +: 96] == '0) && (m_tdata[cpd_pkg::OUT_BYTES_LSB +: cpd_pkg::PBYTES_W] == '0) && (m_tdata[cpd_pkg::OUT_ERR_LSB +: 3] <= cpd_pkg::ERR_TOO_LARGE), "error reply with stray fields")

endmodule

bind command_packet_deframer cpd_checker u_cpd_checker (.*);
